// ===== sv/fk_pkg.sv =====
`default_nettype none
package fk_pkg;

	typedef logic signed [17:0] trig_t;
	typedef logic signed [37:0] q32_t;

	typedef struct packed {
		q32_t h00;
		q32_t h10;
		q32_t h20;
		q32_t h01;
		q32_t h11;
		q32_t h21;
		q32_t h02;
		q32_t h12;
		q32_t h22;
		q32_t sfst;
	} pose_t;

	localparam logic [1:0] REG_DEGREE_MODE = 2'd0;
	localparam logic [1:0] REG_RCM_OFFSET  = 2'd1;
	localparam logic [1:0] REG_BASE_HEIGHT = 2'd2;
	localparam logic [1:0] REG_TOOL_OFFSET = 2'd3;

	localparam logic [14:0] RCM_RESET  = 15'd2212;
	localparam logic [15:0] BASE_RESET = 16'd4997;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [40:0] RAD_TO_TURN = 41'sd166886;
	localparam logic signed [40:0] DEG_TO_TURN = 41'sd23860929;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

	localparam logic [29:0] ATAN_TURNS [24] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
		30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
		30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
	};

endpackage
`default_nettype wire

// ===== sv/platform_forward_kinematics_unit.sv =====
`default_nettype none
// channel | signals                       | beat
// in      | in_valid / in_ready           | x/y positions, pitch, roll, yaw
// out     | out_valid / out_ready         | rot_00..rot_22, pos_x/y/z
// cfg     | cfg_we, cfg_index, cfg_data   | one register write, no wait
//
// One joint vector per cycle unless the output stalls; the path runs through the
// unrolled CORDIC (one stage per iteration) and the product and offset stages.
// Reset clears all valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline; in_ready is high unless a valid output waits on out_ready.
module platform_forward_kinematics_unit #(
	parameter int CORDIC_STAGES = 16,
	parameter int FIELD_WIDTH   = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [FIELD_WIDTH-1:0] x_position,
	input  wire logic signed [FIELD_WIDTH-1:0] y_position,
	input  wire logic signed [15:0]            pitch_angle,
	input  wire logic signed [15:0]            roll_angle,
	input  wire logic signed [15:0]            yaw_angle,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [15:0]                 rot_00,
	output logic signed [15:0]                 rot_10,
	output logic signed [15:0]                 rot_20,
	output logic signed [15:0]                 rot_01,
	output logic signed [15:0]                 rot_11,
	output logic signed [15:0]                 rot_21,
	output logic signed [15:0]                 rot_02,
	output logic signed [15:0]                 rot_12,
	output logic signed [15:0]                 rot_22,
	output logic signed [FIELD_WIDTH-1:0]      pos_x,
	output logic signed [FIELD_WIDTH-1:0]      pos_y,
	output logic signed [FIELD_WIDTH-1:0]      pos_z,
	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [15:0]                   cfg_data
);

	localparam int DL = CORDIC_STAGES + 6;
	localparam int SW = FIELD_WIDTH + 8;
	localparam logic signed [SW-1:0] PMAX =
		{{(SW-FIELD_WIDTH+1){1'b0}}, {(FIELD_WIDTH-1){1'b1}}};
	localparam logic signed [SW-1:0] PMIN = ~PMAX;

	logic               degree_mode_q;
	logic [14:0]        rcm_offset_q;
	logic signed [15:0] base_height_q;
	logic signed [15:0] tool_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_mode_q <= 1'b0;
			rcm_offset_q  <= fk_pkg::RCM_RESET;
			base_height_q <= fk_pkg::BASE_RESET;
			tool_offset_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fk_pkg::REG_DEGREE_MODE: degree_mode_q <= cfg_data[0];
				fk_pkg::REG_RCM_OFFSET:  rcm_offset_q  <= cfg_data[14:0];
				fk_pkg::REG_BASE_HEIGHT: base_height_q <= cfg_data;
				fk_pkg::REG_TOOL_OFFSET: tool_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// angle to binary turn
	function automatic logic [31:0] to_turns(logic signed [15:0] a, logic deg);
		logic signed [40:0] p;
		begin
			p = 41'(a) * (deg ? fk_pkg::DEG_TO_TURN : fk_pkg::RAD_TO_TURN);
			to_turns = deg ? p[39:8] : p[31:0];
		end
	endfunction

	logic        v1_s;
	logic [31:0] th_s1, ph_s1, ps_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s <= 1'b0;
		end else if (en) begin
			v1_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			th_s1 <= 32'd0 - to_turns(pitch_angle, degree_mode_q);
			ph_s1 <= to_turns(roll_angle, degree_mode_q);
			ps_s1 <= to_turns(yaw_angle, degree_mode_q) - fk_pkg::QUARTER_TURN;
		end
	end

	logic          vt, vf, vp;
	fk_pkg::trig_t st, ct, sf, cf, sp, cp;

	fk_sincos #(.STAGES(CORDIC_STAGES)) u_pitch (
		.clk, .arst_n, .en, .in_valid(v1_s), .phase(th_s1),
		.out_valid(vt), .sin_q(st), .cos_q(ct)
	);
	fk_sincos #(.STAGES(CORDIC_STAGES)) u_roll (
		.clk, .arst_n, .en, .in_valid(v1_s), .phase(ph_s1),
		.out_valid(vf), .sin_q(sf), .cos_q(cf)
	);
	fk_sincos #(.STAGES(CORDIC_STAGES)) u_yaw (
		.clk, .arst_n, .en, .in_valid(v1_s), .phase(ps_s1),
		.out_valid(vp), .sin_q(sp), .cos_q(cp)
	);

	logic          vh;
	fk_pkg::pose_t pose;

	fk_pose u_pose (
		.clk, .arst_n, .en, .in_valid(vt), .st, .ct, .sf, .cf, .sp, .cp,
		.out_valid(vh), .pose
	);

	// carry the prismatic positions alongside the angle path
	logic signed [FIELD_WIDTH-1:0] xp_d [0:DL-1];
	logic signed [FIELD_WIDTH-1:0] yp_d [0:DL-1];

	always_ff @(posedge clk) begin
		if (en) begin
			xp_d[0] <= x_position;
			yp_d[0] <= y_position;
			for (int k = 1; k < DL; k++) begin
				xp_d[k] <= xp_d[k-1];
				yp_d[k] <= yp_d[k-1];
			end
		end
	end

	function automatic logic signed [15:0] rot_q14(fk_pkg::q32_t h);
		fk_pkg::q32_t r;
		begin
			r = (h + 38'sd131072) >>> 18;
			if (r > 38'sd16384)       rot_q14 = 16'sd16384;
			else if (r < -38'sd16384) rot_q14 = -16'sd16384;
			else                      rot_q14 = r[15:0];
		end
	endfunction

	logic                          vd_s;
	logic signed [15:0]            rot_d_s [9];
	logic signed [55:0]            mx1_s, mx2_s, my1_s, my2_s, mz1_s, mz2_s;
	logic signed [FIELD_WIDTH-1:0] xp_s2, yp_s2;
	logic signed [15:0]            rcm_s;

	assign rcm_s = $signed({1'b0, rcm_offset_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd_s <= 1'b0;
		end else if (en) begin
			vd_s <= vh;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_d_s[0] <= rot_q14(pose.h00);
			rot_d_s[1] <= rot_q14(pose.h10);
			rot_d_s[2] <= rot_q14(pose.h20);
			rot_d_s[3] <= rot_q14(pose.h01);
			rot_d_s[4] <= rot_q14(pose.h11);
			rot_d_s[5] <= rot_q14(pose.h21);
			rot_d_s[6] <= rot_q14(pose.h02);
			rot_d_s[7] <= rot_q14(pose.h12);
			rot_d_s[8] <= rot_q14(pose.h22);
			mx1_s <= 56'(rcm_s) * 56'(pose.sfst);
			mx2_s <= 56'(tool_offset_q) * 56'(pose.h00);
			my1_s <= 56'(rcm_s) * 56'(pose.h12);
			my2_s <= 56'(tool_offset_q) * 56'(pose.h10);
			mz1_s <= 56'(rcm_s) * 56'(pose.h22);
			mz2_s <= 56'(tool_offset_q) * 56'(pose.h20);
			xp_s2 <= xp_d[DL-1];
			yp_s2 <= yp_d[DL-1];
		end
	end

	function automatic logic signed [SW-1:0] off_q14(logic signed [55:0] m);
		logic signed [55:0] r;
		begin
			r = (m + 56'sh8000_0000) >>> 32;
			off_q14 = r[SW-1:0];
		end
	endfunction

	function automatic logic signed [FIELD_WIDTH-1:0] sat(logic signed [SW-1:0] v);
		begin
			if (v > PMAX)      sat = PMAX[FIELD_WIDTH-1:0];
			else if (v < PMIN) sat = PMIN[FIELD_WIDTH-1:0];
			else               sat = v[FIELD_WIDTH-1:0];
		end
	endfunction

	logic signed [SW-1:0] sx, sy, sz;
	assign sx = SW'(xp_s2) + off_q14(mx1_s) + off_q14(mx2_s);
	assign sy = SW'(yp_s2) + off_q14(my1_s) + off_q14(my2_s);
	assign sz = off_q14(mz1_s) + off_q14(mz2_s) + SW'(base_height_q);

	logic ve_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ve_q <= 1'b0;
		end else if (en) begin
			ve_q <= vd_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_00 <= rot_d_s[0];
			rot_10 <= rot_d_s[1];
			rot_20 <= rot_d_s[2];
			rot_01 <= rot_d_s[3];
			rot_11 <= rot_d_s[4];
			rot_21 <= rot_d_s[5];
			rot_02 <= rot_d_s[6];
			rot_12 <= rot_d_s[7];
			rot_22 <= rot_d_s[8];
			pos_x  <= sat(sx);
			pos_y  <= sat(sy);
			pos_z  <= sat(sz);
		end
	end

	assign out_valid = ve_q;

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(vt == vf) && (vf == vp))
		else $error("sine/cosine lanes out of step");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_z) && $stable(rot_11))
		else $error("result changed while stalled");

	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rot_00 <= 16'sd16384 && rot_00 >= -16'sd16384
			&& rot_22 <= 16'sd16384 && rot_22 >= -16'sd16384))
		else $error("rotation entry beyond one");

endmodule
`default_nettype wire

// ===== sv/fk_sincos.sv =====
`default_nettype none
module fk_sincos #(
	parameter int STAGES = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire logic [31:0]    phase,
	output logic                out_valid,
	output fk_pkg::trig_t       sin_q,
	output fk_pkg::trig_t       cos_q
);

	logic signed [33:0] x_s [0:STAGES];
	logic signed [33:0] y_s [0:STAGES];
	logic signed [33:0] z_s [0:STAGES];
	logic               flip_s [0:STAGES];
	logic               v_s [0:STAGES];
	logic               v_q;

	logic        flip;
	logic [31:0] ph_f;
	assign flip = phase[31] ^ phase[30];
	assign ph_f = flip ? phase + fk_pkg::HALF_TURN : phase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= fk_pkg::CORDIC_GAIN;
			y_s[0]    <= '0;
			z_s[0]    <= 34'($signed(ph_f));
			flip_s[0] <= flip;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		logic signed [33:0] dx, dy, at;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign at = 34'($signed({1'b0, fk_pkg::ATAN_TURNS[i]}));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (!z_s[i][33]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + at;
				end
			end
		end
	end

	logic signed [33:0] xn, yn, xr, yr;
	assign xn = flip_s[STAGES] ? -x_s[STAGES] : x_s[STAGES];
	assign yn = flip_s[STAGES] ? -y_s[STAGES] : y_s[STAGES];
	assign xr = (xn + 34'sd8192) >>> 14;
	assign yr = (yn + 34'sd8192) >>> 14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_s[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= xr[17:0];
			sin_q <= yr[17:0];
		end
	end

	assign out_valid = v_q;

endmodule
`default_nettype wire

// ===== sv/fk_pose.sv =====
`default_nettype none
module fk_pose (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  fk_pkg::trig_t      st,
	input  fk_pkg::trig_t      ct,
	input  fk_pkg::trig_t      sf,
	input  fk_pkg::trig_t      cf,
	input  fk_pkg::trig_t      sp,
	input  fk_pkg::trig_t      cp,
	output logic               out_valid,
	output fk_pkg::pose_t      pose
);

	logic va_s, vb_s, vc_s;

	// two-factor products, Q32
	logic signed [35:0] sfst_a_s, ctsf_a_s, spcf_a_s, cpct_a_s, cpcf_a_s;
	logic signed [35:0] ctsp_a_s, spst_a_s, cfst_a_s, cfct_a_s, cpst_a_s;
	fk_pkg::trig_t      sp_a_s, cp_a_s, sf_a_s;

	// three-factor products, Q48
	logic signed [53:0] t1_b_s, t2_b_s, t3_b_s, t4_b_s;
	logic signed [35:0] sfst_b_s, spcf_b_s, cpct_b_s, cpcf_b_s;
	logic signed [35:0] ctsp_b_s, spst_b_s, cfst_b_s, cfct_b_s, cpst_b_s;
	fk_pkg::trig_t      sf_b_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_s <= 1'b0;
			vb_s <= 1'b0;
			vc_s <= 1'b0;
		end else if (en) begin
			va_s <= in_valid;
			vb_s <= va_s;
			vc_s <= vb_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sfst_a_s <= 36'(sf) * 36'(st);
			ctsf_a_s <= 36'(ct) * 36'(sf);
			spcf_a_s <= 36'(sp) * 36'(cf);
			cpct_a_s <= 36'(cp) * 36'(ct);
			cpcf_a_s <= 36'(cp) * 36'(cf);
			ctsp_a_s <= 36'(ct) * 36'(sp);
			spst_a_s <= 36'(sp) * 36'(st);
			cfst_a_s <= 36'(cf) * 36'(st);
			cfct_a_s <= 36'(cf) * 36'(ct);
			cpst_a_s <= 36'(cp) * 36'(st);
			sp_a_s   <= sp;
			cp_a_s   <= cp;
			sf_a_s   <= sf;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t1_b_s   <= 54'(sfst_a_s) * 54'(sp_a_s);
			t2_b_s   <= 54'(ctsf_a_s) * 54'(sp_a_s);
			t3_b_s   <= 54'(sfst_a_s) * 54'(cp_a_s);
			t4_b_s   <= 54'(ctsf_a_s) * 54'(cp_a_s);
			sfst_b_s <= sfst_a_s;
			spcf_b_s <= spcf_a_s;
			cpct_b_s <= cpct_a_s;
			cpcf_b_s <= cpcf_a_s;
			ctsp_b_s <= ctsp_a_s;
			spst_b_s <= spst_a_s;
			cfst_b_s <= cfst_a_s;
			cfct_b_s <= cfct_a_s;
			cpst_b_s <= cpst_a_s;
			sf_b_s   <= sf_a_s;
		end
	end

	// round Q48 down to Q32, half up
	logic signed [53:0] r1, r2, r3, r4;
	assign r1 = (t1_b_s + 54'sd32768) >>> 16;
	assign r2 = (t2_b_s + 54'sd32768) >>> 16;
	assign r3 = (t3_b_s + 54'sd32768) >>> 16;
	assign r4 = (t4_b_s + 54'sd32768) >>> 16;

	fk_pkg::pose_t pose_c_s;

	always_ff @(posedge clk) begin
		if (en) begin
			pose_c_s.h00  <= -38'(spcf_b_s);
			pose_c_s.h10  <= 38'(cpct_b_s) + r1[37:0];
			pose_c_s.h20  <= r2[37:0] - 38'(cpst_b_s);
			pose_c_s.h01  <= -38'(cpcf_b_s);
			pose_c_s.h11  <= r3[37:0] - 38'(ctsp_b_s);
			pose_c_s.h21  <= 38'(spst_b_s) + r4[37:0];
			pose_c_s.h02  <= 38'(sf_b_s) <<< 16;
			pose_c_s.h12  <= 38'(cfst_b_s);
			pose_c_s.h22  <= 38'(cfct_b_s);
			pose_c_s.sfst <= 38'(sfst_b_s);
		end
	end

	assign out_valid = vc_s;
	assign pose      = pose_c_s;

endmodule
`default_nettype wire

// ===== verif/tb_platform_forward_kinematics_unit.sv =====
`default_nettype none
module tb_platform_forward_kinematics_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STAGES = 16;
	localparam int SETTLE = STAGES + 16;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [15:0] xp;
		logic signed [15:0] yp;
		logic signed [15:0] pitch;
		logic signed [15:0] roll;
		logic signed [15:0] yaw;
	} joint_vec_t;

	typedef logic [11:0][15:0] pose_vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] x_position = '0, y_position = '0;
	logic signed [15:0] pitch_angle = '0, roll_angle = '0, yaw_angle = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] rot_00, rot_10, rot_20, rot_01, rot_11, rot_21;
	logic signed [15:0] rot_02, rot_12, rot_22, pos_x, pos_y, pos_z;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	platform_forward_kinematics_unit dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow registers
	logic deg_mode = 1'b0;
	longint rcm_off = 2212, base_hgt = 4997, tool_off = 0;

	joint_vec_t pending_joints[$];
	pose_vec_t expected_poses[$];
	int snd_idle = 0, rcv_idle = 0;
	int errors = 0;
	int cycles = 0;
	int hold_cycles = 0;
	bit hold_req = 0;
	logic in_taken = 1'b0;

	function automatic longint rnd_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic logic [31:0] angle_turns(logic signed [15:0] a);
		longint p;
		if (deg_mode) begin
			p = longint'(a) * 23860929;
			return 32'(p >> 8);
		end
		p = longint'(a) * 166886;
		return 32'(p);
	endfunction

	function automatic void sin_cos(logic [31:0] ph, output longint s, output longint c);
		longint x, y, z, dx, dy;
		logic [1:0] quad;
		bit flip;
		quad = ph[31:30];
		flip = (quad == 2'd1) || (quad == 2'd2);
		if (flip)
			ph = ph + fk_pkg::HALF_TURN;
		z = longint'($signed(ph));
		x = longint'(fk_pkg::CORDIC_GAIN);
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(fk_pkg::ATAN_TURNS[i]);
			end else begin
				x += dx; y -= dy; z += longint'(fk_pkg::ATAN_TURNS[i]);
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = rnd_shift(x, 14);
		s = rnd_shift(y, 14);
	endfunction

	function automatic logic [15:0] rot_q14(longint v);
		longint r;
		r = rnd_shift(v, 18);
		if (r > 16384) r = 16384;
		if (r < -16384) r = -16384;
		return 16'(r);
	endfunction

	function automatic logic [15:0] pos_sat(longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return 16'(v);
	endfunction

	function automatic pose_vec_t predict_pose(joint_vec_t j);
		longint st, ct, sf, cf, sp, cp;
		longint h00, h10, h20, h01, h11, h21, h02, h12, h22, sfst;
		pose_vec_t r;
		sin_cos(32'd0 - angle_turns(j.pitch), st, ct);
		sin_cos(angle_turns(j.roll), sf, cf);
		sin_cos(angle_turns(j.yaw) - fk_pkg::QUARTER_TURN, sp, cp);
		sfst = sf * st;
		h00 = -(sp * cf);
		h10 = cp * ct + rnd_shift(sp * sf * st, 16);
		h20 = rnd_shift(ct * sf * sp, 16) - cp * st;
		h01 = -(cp * cf);
		h11 = rnd_shift(cp * sf * st, 16) - ct * sp;
		h21 = sp * st + rnd_shift(cp * ct * sf, 16);
		h02 = sf * 65536;
		h12 = cf * st;
		h22 = cf * ct;
		r[0] = rot_q14(h00); r[1] = rot_q14(h10); r[2] = rot_q14(h20);
		r[3] = rot_q14(h01); r[4] = rot_q14(h11); r[5] = rot_q14(h21);
		r[6] = rot_q14(h02); r[7] = rot_q14(h12); r[8] = rot_q14(h22);
		r[9] = pos_sat(longint'(j.xp) + rnd_shift(rcm_off * sfst, 32)
			+ rnd_shift(tool_off * h00, 32));
		r[10] = pos_sat(longint'(j.yp) + rnd_shift(rcm_off * h12, 32)
			+ rnd_shift(tool_off * h10, 32));
		r[11] = pos_sat(rnd_shift(rcm_off * h22, 32) + rnd_shift(tool_off * h20, 32)
			+ base_hgt);
		return r;
	endfunction

	task automatic report(string what, int idx, logic [15:0] got, logic [15:0] want);
		$display("pose mismatch: %s field %0d got %0d want %0d", what, idx,
			$signed(got), $signed(want));
		errors++;
	endtask

	// sender
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (pending_joints.size() > 0 && $urandom_range(99) >= snd_idle) begin
				joint_vec_t j;
				j = pending_joints.pop_front();
				in_valid <= 1'b1;
				x_position <= j.xp; y_position <= j.yp;
				pitch_angle <= j.pitch; roll_angle <= j.roll; yaw_angle <= j.yaw;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_cycles = 300;
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	always @(posedge clk) begin
		pose_vec_t got, want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
		in_taken <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			expected_poses.push_back(predict_pose({x_position, y_position,
				pitch_angle, roll_angle, yaw_angle}));
		if (arst_n && out_valid && out_ready) begin
			got = {pos_z, pos_y, pos_x, rot_22, rot_12, rot_02,
				rot_21, rot_11, rot_01, rot_20, rot_10, rot_00};
			if (expected_poses.size() == 0) begin
				report("unexpected beat", 0, 16'd0, 16'd0);
			end else begin
				want = expected_poses.pop_front();
				for (int k = 0; k < 12; k++)
					if (got[k] !== want[k])
						report("beat", k, got[k], want[k]);
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] d);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= d;
		case (idx)
			fk_pkg::REG_DEGREE_MODE: deg_mode = d[0];
			fk_pkg::REG_RCM_OFFSET:  rcm_off = longint'(d[14:0]);
			fk_pkg::REG_BASE_HEIGHT: base_hgt = longint'($signed(d));
			fk_pkg::REG_TOOL_OFFSET: tool_off = longint'($signed(d));
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(logic dm, logic [15:0] rcm, logic [15:0] bh, logic [15:0] to);
		write_reg(fk_pkg::REG_DEGREE_MODE, {15'd0, dm});
		write_reg(fk_pkg::REG_RCM_OFFSET, rcm);
		write_reg(fk_pkg::REG_BASE_HEIGHT, bh);
		write_reg(fk_pkg::REG_TOOL_OFFSET, to);
	endtask

	task automatic add_joint(logic [15:0] xp, yp, pt, rl, yw);
		pending_joints.push_back({xp, yp, pt, rl, yw});
	endtask

	function automatic logic [15:0] rand_angle();
		case ($urandom_range(3))
			0: return 16'($urandom_range(0, 2000)) - 16'd1000;
			1: return 16'($urandom_range(0, 50000)) - 16'd25000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_directed();
		logic [15:0] q, h;
		q = deg_mode ? 16'd11520 : 16'd12868;
		h = deg_mode ? 16'd23040 : 16'd25736;
		add_joint(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		add_joint(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		add_joint(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		add_joint(16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'hffff);
		add_joint(16'd0, 16'd0, q, 16'd0, 16'd0);
		add_joint(16'd0, 16'd0, -q, 16'd0, 16'd0);
		add_joint(16'd0, 16'd0, 16'd0, q, 16'd0);
		add_joint(16'd0, 16'd0, 16'd0, -q, 16'd0);
		add_joint(16'd0, 16'd0, 16'd0, 16'd0, q);
		add_joint(16'd0, 16'd0, 16'd0, 16'd0, -q);
		add_joint(16'd0, 16'd0, h, h, h);
		add_joint(16'd0, 16'd0, -h, -h, -h);
		add_joint(16'h7fff, 16'h7fff, q, q, h);
		add_joint(16'h8000, 16'h8000, -q, -q, 16'd0);
		add_joint(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
		add_joint(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
	endtask

	task automatic add_random(int n);
		repeat (n)
			add_joint(16'($urandom), 16'($urandom), rand_angle(), rand_angle(), rand_angle());
	endtask

	task automatic drain();
		while (pending_joints.size() > 0 || in_valid || expected_poses.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values first
		snd_idle = 21; rcv_idle = 53;
		add_directed();
		add_random(250);
		drain();

		set_regs(1'b1, 16'h7fff, 16'h8000, 16'h7fff);
		add_directed();
		add_random(250);
		drain();

		snd_idle = 53; rcv_idle = 21;
		set_regs(1'b0, 16'h0000, 16'h7fff, 16'h8000);
		hold_req = 1;
		add_random(250);
		drain();

		set_regs(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
		add_random(250);
		drain();

		snd_idle = 0; rcv_idle = 0;
		set_regs(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
		hold_req = 1;
		add_random(280);
		drain();

		set_regs(1'b1, 16'h7fff, 16'h7fff, 16'h8000);
		add_random(280);
		drain();

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
sv/fk_pkg.sv
sv/fk_sincos.sv
sv/fk_pose.sv
sv/platform_forward_kinematics_unit.sv
verif/tb_platform_forward_kinematics_unit.sv
